// ===== sv/sts_pkg.sv =====
package sts_pkg;

  localparam int ANGLE_W = 32;
  localparam int TERMS_W = 4;
  localparam int SUM_W   = 32;
  localparam int XMAG_W  = 32;
  localparam int X2_W    = 32;
  localparam int FAC_W   = 32;
  localparam int TMAG_W  = 36;
  localparam int ACC_W   = 40;
  localparam int PROD_W  = TMAG_W + FAC_W;
  localparam int RECIP_AW = 5;
  localparam int RECIP_N  = 2 ** RECIP_AW;

  localparam logic [63:0] TWO32 = 64'h1_0000_0000;

  // Reciprocal table: round-half-up of 2^32 / ((2k)(2k+1)), Q0.32; entry 0 unused.
  localparam logic [31:0] RECIP [RECIP_N] = '{
    32'd0,
    32'((TWO32 + 64'd3)    / 64'd6),
    32'((TWO32 + 64'd10)   / 64'd20),
    32'((TWO32 + 64'd21)   / 64'd42),
    32'((TWO32 + 64'd36)   / 64'd72),
    32'((TWO32 + 64'd55)   / 64'd110),
    32'((TWO32 + 64'd78)   / 64'd156),
    32'((TWO32 + 64'd105)  / 64'd210),
    32'((TWO32 + 64'd136)  / 64'd272),
    32'((TWO32 + 64'd171)  / 64'd342),
    32'((TWO32 + 64'd210)  / 64'd420),
    32'((TWO32 + 64'd253)  / 64'd506),
    32'((TWO32 + 64'd300)  / 64'd600),
    32'((TWO32 + 64'd351)  / 64'd702),
    32'((TWO32 + 64'd406)  / 64'd812),
    32'((TWO32 + 64'd465)  / 64'd930),
    32'((TWO32 + 64'd528)  / 64'd1056),
    32'((TWO32 + 64'd595)  / 64'd1190),
    32'((TWO32 + 64'd666)  / 64'd1332),
    32'((TWO32 + 64'd741)  / 64'd1482),
    32'((TWO32 + 64'd820)  / 64'd1640),
    32'((TWO32 + 64'd903)  / 64'd1806),
    32'((TWO32 + 64'd990)  / 64'd1980),
    32'((TWO32 + 64'd1081) / 64'd2162),
    32'((TWO32 + 64'd1176) / 64'd2352),
    32'((TWO32 + 64'd1275) / 64'd2550),
    32'((TWO32 + 64'd1378) / 64'd2756),
    32'((TWO32 + 64'd1485) / 64'd2970),
    32'((TWO32 + 64'd1596) / 64'd3192),
    32'((TWO32 + 64'd1711) / 64'd3422),
    32'((TWO32 + 64'd1830) / 64'd3660),
    32'((TWO32 + 64'd1953) / 64'd3906)
  };

  typedef enum logic [1:0] {
    MUL_NONE   = 2'd0,
    MUL_SQUARE = 2'd1,
    MUL_FACTOR = 2'd2,
    MUL_TERM   = 2'd3
  } mul_op_t;

  typedef struct packed {
    logic                load;
    mul_op_t             mul;
    logic [RECIP_AW-1:0] k;
    logic                acc_add;
    logic                finish;
  } sts_cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_status_t;

endpackage

// ===== sv/sts_ctrl.sv =====
module sts_ctrl #(
  parameter int MAX_TERMS = 15
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sts_pkg::TERMS_W-1:0] terms,
  input  sts_pkg::sts_status_t        status,
  output sts_pkg::sts_cmd_t           cmd
);
  import sts_pkg::*;

  localparam int KW = $clog2(MAX_TERMS + 1);
  localparam int CW = 6;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SQUARE = 6'b000010,
    ST_FACTOR = 6'b000100,
    ST_TERM   = 6'b001000,
    ST_ACCUM  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t        state, state_next;
  logic [KW-1:0] k, k_next;
  logic [KW-1:0] n, n_next;
  logic [CW-1:0] terms_ext;

  assign terms_ext = CW'(terms);
  assign in_ready  = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    k_next      = k;
    n_next      = n;
    cmd.load    = 1'b0;
    cmd.mul     = MUL_NONE;
    cmd.k       = RECIP_AW'(k);
    cmd.acc_add = 1'b0;
    cmd.finish  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          k_next     = KW'(1);
          n_next     = (terms_ext > CW'(MAX_TERMS)) ? KW'(MAX_TERMS) : KW'(terms_ext);
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.mul    = MUL_SQUARE;
        state_next = (n == '0) ? ST_FINISH : ST_FACTOR;
      end
      ST_FACTOR: begin
        // fold the previous term into the sum while the next factor forms
        cmd.mul     = MUL_FACTOR;
        cmd.acc_add = (k != KW'(1));
        state_next  = ST_TERM;
      end
      ST_TERM: begin
        cmd.mul = MUL_TERM;
        if (k == n) begin
          state_next = ST_ACCUM;
        end else begin
          k_next     = k + KW'(1);
          state_next = ST_FACTOR;
        end
      end
      ST_ACCUM: begin
        cmd.acc_add = 1'b1;
        state_next  = ST_FINISH;
      end
      ST_FINISH: begin
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
      n     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
      n     <= n_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_SQUARE)
    else $error("accepted item did not start the square step");

  a_k_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FACTOR || state == ST_TERM) |-> (k >= KW'(1) && k <= n))
    else $error("term index out of range");

  a_last_term: assert property (@(posedge clk) disable iff (rst)
    state == ST_TERM && k == n |=> state == ST_ACCUM && cmd.acc_add)
    else $error("last term not accumulated");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !status.out_busy)
    else $error("result written over a waiting result");
`endif

endmodule

// ===== sv/sts_dp.sv =====
module sts_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [sts_pkg::ANGLE_W-1:0] angle,
  input  sts_pkg::sts_cmd_t           cmd,
  output sts_pkg::sts_status_t        status,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sts_pkg::SUM_W-1:0]   sum,
  output logic                        saturated
);
  import sts_pkg::*;

  localparam int QW = ACC_W - 6;

  logic [XMAG_W-1:0] xmag;
  logic [X2_W-1:0]   x2;
  logic [FAC_W-1:0]  fac;
  logic [TMAG_W-1:0] tmag;
  logic              tneg;
  logic signed [ACC_W-1:0] acc;

  logic [TMAG_W-1:0] mul_a;
  logic [FAC_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_rnd;
  logic [PROD_W-1:0] prod;

  logic [XMAG_W-1:0]       angle_mag;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [QW-1:0]    q24;
  logic                    q_sat;

  assign angle_mag = angle[ANGLE_W-1] ? (~angle + XMAG_W'(1)) : angle;

  // shared multiplier, rounding constant folded into the product
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_rnd = '0;
    case (cmd.mul)
      MUL_SQUARE: begin
        mul_a   = TMAG_W'(xmag);
        mul_b   = FAC_W'(xmag);
        mul_rnd = PROD_W'(1) << 30;
      end
      MUL_FACTOR: begin
        mul_a   = TMAG_W'(x2);
        mul_b   = RECIP[cmd.k];
        mul_rnd = PROD_W'(1) << 31;
      end
      MUL_TERM: begin
        mul_a   = tmag;
        mul_b   = fac;
        mul_rnd = PROD_W'(1) << 26;
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b + mul_rnd;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xmag <= angle_mag;
      tmag <= {{(TMAG_W-XMAG_W-1){1'b0}}, angle_mag, 1'b0};
      tneg <= angle[ANGLE_W-1];
      acc  <= ACC_W'(signed'(angle)) <<< 1;
    end
    case (cmd.mul)
      MUL_SQUARE: x2 <= prod[62:31];
      MUL_FACTOR: fac <= prod[63:32];
      MUL_TERM: begin
        tmag <= prod[62:27];
        tneg <= ~tneg;
      end
      default: ;
    endcase
    if (cmd.acc_add) begin
      acc <= tneg ? (acc - signed'(ACC_W'(tmag))) : (acc + signed'(ACC_W'(tmag)));
    end
  end

  // round half up to Q.24, then clip to 32 bits
  assign acc_rnd = acc + ACC_W'(32);
  assign q24     = acc_rnd[ACC_W-1:6];
  assign q_sat   = !((q24[QW-1:SUM_W-1] == '0) || (q24[QW-1:SUM_W-1] == '1));

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      saturated <= q_sat;
      if (!q_sat) begin
        sum <= q24[SUM_W-1:0];
      end else if (q24[QW-1]) begin
        sum <= {1'b1, {(SUM_W-1){1'b0}}};
      end else begin
        sum <= {1'b0, {(SUM_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.out_busy = out_valid && !out_ready;

endmodule

// ===== sv/sine_taylor_series_top.sv =====
// Channel  Dir  Signals                       Contents
// s_       in   s_tvalid s_tready s_tdata     angle x Q2.29, term count n
// m_       out  m_tvalid m_tready m_tdata     sine sum Q7.24, saturation flag
//
// Terms: n capped at MAX_TERMS; one shared multiplier serves two dependent products a term.
// The next item is accepted the cycle after the result lands in the output register.
// Reset: synchronous, active high; clears the controller and the output valid.
// Stalls: a result waiting on m_tready holds the block in its last step only
// if a second result is ready to be written; the output register parts the sides.
module sine_taylor_series_top #(
  parameter int MAX_TERMS = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] angle, [35:32] terms, [39:36] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] sum
  output logic [0:0]  m_tuser    // [0] saturated
);
  import sts_pkg::*;

  sts_cmd_t    cmd;
  sts_status_t status;
  logic        sat;

  // Sequence the square, the per-term factor and term products, and the final write.
  sts_ctrl #(
    .MAX_TERMS (MAX_TERMS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .terms    (s_tdata[35:32]),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold operands, the running sum and the output register.
  sts_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .angle     (s_tdata[31:0]),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sum       (m_tdata),
    .saturated (sat)
  );

  assign m_tuser = sat;

endmodule
